[rtl/wsc_pkg.sv]
// wsc_pkg: shared constants, codes and control/status types of the stereo correlation meter
// no dependencies; used by the interfaces, wsc_ctrl, wsc_dpath and the top level
`default_nettype none

package wsc_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COUNT_BITS  = 16;

  // window register
  localparam int WINDOW_BITS       = 16;
  localparam int REF_SAMPLE_RATE   = 48000;
  localparam int WINDOW_PER_SECOND = 20;
  localparam logic [WINDOW_BITS-1:0] WINDOW_LENGTH_RESET =
    WINDOW_BITS'(REF_SAMPLE_RATE / WINDOW_PER_SECOND);

  // result format and root search
  localparam int CORR_BITS  = 16;
  localparam int A_SHIFT    = 32;
  localparam logic [CORR_BITS-1:0] SEARCH_HI = 16'd32768;
  localparam logic [CORR_BITS-1:0] CORR_MAX  = 16'd32767;

  // apb
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam logic [APB_ADDR_BITS-3:0] REG_WINDOW_LENGTH = '0;

  // item actions
  localparam logic [1:0] ACT_SAMPLE   = 2'd0;
  localparam logic [1:0] ACT_FINISH   = 2'd1;
  localparam logic [1:0] ACT_RESTART  = 2'd2;
  localparam logic [1:0] ACT_RESERVED = 2'd3;

  // multiplier operand selects, also the sequencer step codes
  localparam logic [3:0] SEL_N_SLR   = 4'd0;
  localparam logic [3:0] SEL_SL_SR   = 4'd1;
  localparam logic [3:0] SEL_N_SLL   = 4'd2;
  localparam logic [3:0] SEL_SL_SL   = 4'd3;
  localparam logic [3:0] SEL_N_SRR   = 4'd4;
  localparam logic [3:0] SEL_SR_SR   = 4'd5;
  localparam logic [3:0] SEL_DL_DR   = 4'd6;
  localparam logic [3:0] SEL_NUM_NUM = 4'd7;
  localparam logic [3:0] SEL_O_O     = 4'd8;
  localparam logic [3:0] SEL_OO_D    = 4'd9;

  typedef struct packed {
    logic       accept;       // input transfer this cycle
    logic       mul_start;    // load multiplier operands
    logic [3:0] sel;          // operand pair / destination
    logic       store;        // write product to its destination
    logic       search_init;  // reset root search bounds
    logic       load_out;     // load result register and clear window
  } wsc_cmd_t;

  typedef struct packed {
    logic emit_req;     // incoming item closes a window
    logic mul_done;
    logic den_ok;       // both variance terms positive
    logic search_done;
    logic out_busy;     // result register still held
  } wsc_sts_t;

endpackage

`default_nettype wire

[rtl/wsc_ifs.sv]
// wsc_in_if / wsc_out_if: valid-ready channels of the stereo correlation meter
// depends on wsc_pkg for default widths
`default_nettype none

interface wsc_in_if #(parameter int SAMPLE_BITS = wsc_pkg::SAMPLE_BITS);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  modport source (output valid, action, left_sample, right_sample, input ready);
  modport sink (input valid, action, left_sample, right_sample, output ready);
endinterface

interface wsc_out_if #(parameter int COUNT_BITS = wsc_pkg::COUNT_BITS);
  logic                                 valid;
  logic                                 ready;
  logic signed [wsc_pkg::CORR_BITS-1:0] correlation;
  logic [COUNT_BITS-1:0]                window_samples;
  logic                                 partial_window;
  modport source (output valid, correlation, window_samples, partial_window, input ready);
  modport sink (input valid, correlation, window_samples, partial_window, output ready);
endinterface

`default_nettype wire

[rtl/wsc_dpath.sv]
// wsc_dpath: window accumulators, shared shift-add multiplier, root search, result register
// depends on wsc_pkg; driven by wsc_ctrl
`default_nettype none

module wsc_dpath #(
  parameter int SAMPLE_BITS = wsc_pkg::SAMPLE_BITS,
  parameter int COUNT_BITS  = wsc_pkg::COUNT_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire wsc_pkg::wsc_cmd_t                    cmd,
  output      wsc_pkg::wsc_sts_t                    sts,
  input  wire logic [1:0]                           in_action,
  input  wire logic signed [SAMPLE_BITS-1:0]        in_left,
  input  wire logic signed [SAMPLE_BITS-1:0]        in_right,
  input  wire logic [wsc_pkg::WINDOW_BITS-1:0]      window_length,
  input  wire logic                                 out_ready,
  output      logic                                 out_valid,
  output      logic signed [wsc_pkg::CORR_BITS-1:0] out_corr,
  output      logic [COUNT_BITS-1:0]                out_samples,
  output      logic                                 out_partial
);

  localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
  localparam int SQ_W  = 2 * SAMPLE_BITS + COUNT_BITS;
  localparam int MAG_W = 2 * SAMPLE_BITS + 2 * COUNT_BITS;
  localparam int MB    = MAG_W + 1;
  localparam int W     = 2 * MAG_W + wsc_pkg::A_SHIFT + 4;
  localparam int CB    = wsc_pkg::CORR_BITS;
  localparam int WB    = wsc_pkg::WINDOW_BITS;
  localparam logic [WB:0] CNT_MAX = (WB + 1)'((64'd1 << COUNT_BITS) - 64'd1);

  // window accumulators
  logic [COUNT_BITS-1:0]   count_r;
  logic signed [SUM_W-1:0] sum_l_r, sum_r_r;
  logic signed [SQ_W-1:0]  sum_ll_r, sum_rr_r, sum_lr_r;
  logic                    partial_r;

  logic signed [2*SAMPLE_BITS-1:0] prod_ll, prod_rr, prod_lr;
  logic [COUNT_BITS:0]             count_inc;
  logic [WB:0]                     win_x;
  logic [COUNT_BITS:0]             win_eff;

  assign prod_ll   = in_left * in_left;
  assign prod_rr   = in_right * in_right;
  assign prod_lr   = in_left * in_right;
  assign count_inc = {1'b0, count_r} + (COUNT_BITS + 1)'(1);
  assign win_x     = {1'b0, window_length};

  always_comb begin
    if (window_length == '0) begin
      win_eff = (COUNT_BITS + 1)'(1);
    end else if (win_x > CNT_MAX) begin
      win_eff = CNT_MAX[COUNT_BITS:0];
    end else begin
      win_eff = win_x[COUNT_BITS:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_out) begin
      count_r  <= '0;
      sum_l_r  <= '0;
      sum_r_r  <= '0;
      sum_ll_r <= '0;
      sum_rr_r <= '0;
      sum_lr_r <= '0;
    end else if (cmd.accept) begin
      unique case (in_action)
        wsc_pkg::ACT_SAMPLE: begin
          count_r  <= count_inc[COUNT_BITS-1:0];
          sum_l_r  <= sum_l_r + SUM_W'(in_left);
          sum_r_r  <= sum_r_r + SUM_W'(in_right);
          sum_ll_r <= sum_ll_r + SQ_W'(prod_ll);
          sum_rr_r <= sum_rr_r + SQ_W'(prod_rr);
          sum_lr_r <= sum_lr_r + SQ_W'(prod_lr);
        end
        wsc_pkg::ACT_RESTART: begin
          count_r  <= '0;
          sum_l_r  <= '0;
          sum_r_r  <= '0;
          sum_ll_r <= '0;
          sum_rr_r <= '0;
          sum_lr_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      partial_r <= (in_action == wsc_pkg::ACT_FINISH);
    end
  end

  assign sts.emit_req = ((in_action == wsc_pkg::ACT_SAMPLE) && (count_inc >= win_eff)) ||
                        ((in_action == wsc_pkg::ACT_FINISH) && (count_r != '0));

  // product terms and search state
  logic signed [W-1:0] p_r, num_r, dl_r, dr_r;
  logic [W-1:0]        d_r, a_r, oo_r;
  logic [CB-1:0]       lo_r, hi_r;
  logic [CB:0]         mid_sum;
  logic [CB-1:0]       mid_c;
  logic [CB:0]         odd_c;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} + (CB + 1)'(1);
  assign mid_c   = mid_sum[CB:1];
  assign odd_c   = {mid_c, 1'b0} - (CB + 1)'(1);

  // operand select
  logic signed [W-1:0] x_s, y_s;
  logic [W-1:0]        x_mag, y_abs;
  logic signed [W-1:0] n_s;

  assign n_s = W'($signed({1'b0, count_r}));

  always_comb begin
    unique case (cmd.sel)
      wsc_pkg::SEL_N_SLR:   begin x_s = W'(sum_lr_r); y_s = n_s; end
      wsc_pkg::SEL_SL_SR:   begin x_s = W'(sum_l_r);  y_s = W'(sum_r_r); end
      wsc_pkg::SEL_N_SLL:   begin x_s = W'(sum_ll_r); y_s = n_s; end
      wsc_pkg::SEL_SL_SL:   begin x_s = W'(sum_l_r);  y_s = W'(sum_l_r); end
      wsc_pkg::SEL_N_SRR:   begin x_s = W'(sum_rr_r); y_s = n_s; end
      wsc_pkg::SEL_SR_SR:   begin x_s = W'(sum_r_r);  y_s = W'(sum_r_r); end
      wsc_pkg::SEL_DL_DR:   begin x_s = dl_r;         y_s = dr_r; end
      wsc_pkg::SEL_NUM_NUM: begin x_s = num_r;        y_s = num_r; end
      wsc_pkg::SEL_O_O: begin
        x_s = W'($signed({1'b0, odd_c}));
        y_s = W'($signed({1'b0, odd_c}));
      end
      default:              begin x_s = $signed(d_r); y_s = $signed(oo_r); end
    endcase
  end

  assign x_mag = x_s[W-1] ? W'(-x_s) : W'(x_s);
  assign y_abs = y_s[W-1] ? W'(-y_s) : W'(y_s);

  // shift-add multiplier, one multiplier bit per cycle
  logic [W-1:0]        ma_r, acc_r;
  logic [MB-1:0]       mb_r;
  logic                neg_r;
  logic [3:0]          sel_r;
  logic signed [W-1:0] prod_s;

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      ma_r  <= x_mag;
      mb_r  <= y_abs[MB-1:0];
      acc_r <= '0;
      neg_r <= x_s[W-1] ^ y_s[W-1];
      sel_r <= cmd.sel;
    end else if (mb_r != '0) begin
      if (mb_r[0]) begin
        acc_r <= acc_r + ma_r;
      end
      ma_r <= ma_r << 1;
      mb_r <= mb_r >> 1;
    end
  end

  assign sts.mul_done = (mb_r == '0);
  assign prod_s       = neg_r ? -$signed(acc_r) : $signed(acc_r);

  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      lo_r <= '0;
      hi_r <= wsc_pkg::SEARCH_HI;
    end
    if (cmd.store) begin
      unique case (sel_r)
        wsc_pkg::SEL_N_SLR, wsc_pkg::SEL_N_SLL, wsc_pkg::SEL_N_SRR: p_r <= prod_s;
        wsc_pkg::SEL_SL_SR:   num_r <= p_r - prod_s;
        wsc_pkg::SEL_SL_SL:   dl_r  <= p_r - prod_s;
        wsc_pkg::SEL_SR_SR:   dr_r  <= p_r - prod_s;
        wsc_pkg::SEL_DL_DR:   d_r   <= acc_r;
        wsc_pkg::SEL_NUM_NUM: a_r   <= acc_r << wsc_pkg::A_SHIFT;
        wsc_pkg::SEL_O_O:     oo_r  <= acc_r;
        default: begin
          if (a_r >= acc_r) begin
            lo_r <= mid_c;
          end else begin
            hi_r <= mid_c - CB'(1);
          end
        end
      endcase
    end
  end

  assign sts.den_ok      = !dl_r[W-1] && (dl_r != '0) && !dr_r[W-1] && (dr_r != '0);
  assign sts.search_done = (lo_r >= hi_r);

  // result register
  logic [CB-1:0] corr_c;
  logic          out_valid_r;

  always_comb begin
    if (!sts.den_ok) begin
      corr_c = '0;
    end else if (num_r[W-1]) begin
      corr_c = CB'(0) - lo_r;
    end else if (lo_r > wsc_pkg::CORR_MAX) begin
      corr_c = wsc_pkg::CORR_MAX;
    end else begin
      corr_c = lo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_corr    <= $signed(corr_c);
      out_samples <= count_r;
      out_partial <= partial_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.out_busy = out_valid_r && !out_ready;

endmodule

`default_nettype wire

[rtl/wsc_ctrl.sv]
// wsc_ctrl: sequencer of the correlation meter, steps the shared multiplier and root search
// depends on wsc_pkg; commands wsc_dpath
`default_nettype none

module wsc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire wsc_pkg::wsc_sts_t sts,
  output      wsc_pkg::wsc_cmd_t cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MUL_GO  = 3'd1;
  localparam logic [2:0] S_MUL_RUN = 3'd2;
  localparam logic [2:0] S_STORE   = 3'd3;
  localparam logic [2:0] S_CHECK   = 3'd4;
  localparam logic [2:0] S_SEARCH  = 3'd5;
  localparam logic [2:0] S_EMIT    = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [3:0] step_r, step_nxt;

  always_comb begin
    state_nxt       = state_r;
    step_nxt        = step_r;
    cmd             = '0;
    cmd.sel         = step_r;
    in_ready        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && sts.emit_req) begin
          step_nxt  = wsc_pkg::SEL_N_SLR;
          state_nxt = S_MUL_GO;
        end
      end
      S_MUL_GO: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_MUL_RUN;
      end
      S_MUL_RUN: begin
        if (sts.mul_done) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        priority case (step_r)
          wsc_pkg::SEL_SR_SR: state_nxt = S_CHECK;
          wsc_pkg::SEL_NUM_NUM: begin
            cmd.search_init = 1'b1;
            state_nxt       = S_SEARCH;
          end
          wsc_pkg::SEL_OO_D: state_nxt = S_SEARCH;
          default: begin
            step_nxt  = step_r + 4'd1;
            state_nxt = S_MUL_GO;
          end
        endcase
      end
      S_CHECK: begin
        if (sts.den_ok) begin
          step_nxt  = wsc_pkg::SEL_DL_DR;
          state_nxt = S_MUL_GO;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_SEARCH: begin
        if (sts.search_done) begin
          state_nxt = S_EMIT;
        end else begin
          step_nxt  = wsc_pkg::SEL_O_O;
          state_nxt = S_MUL_GO;
        end
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= wsc_pkg::SEL_N_SLR;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  a_window_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && sts.emit_req) |=> (state_r == S_MUL_GO && step_r == wsc_pkg::SEL_N_SLR))
    else $error("window end did not start the product sequence");

  a_mul_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_start |=> (state_r == S_MUL_RUN && $stable(step_r)))
    else $error("step changed while multiplier runs");

  a_search_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |->
      (step_r == wsc_pkg::SEL_NUM_NUM || step_r == wsc_pkg::SEL_OO_D))
    else $error("root search entered from wrong step");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !cmd.accept)
    else $error("transfer taken while computing");

endmodule

`default_nettype wire

[rtl/windowed_stereo_correlation.sv]
// windowed_stereo_correlation: top level, apb window register, controller and datapath
// depends on wsc_pkg, wsc_ifs (wsc_in_if, wsc_out_if), wsc_ctrl, wsc_dpath
//
//   channel   direction  handshake          payload
//   in_ch     sink       valid / ready      action, left_sample, right_sample
//   out_ch    source     valid / ready      correlation, window_samples, partial_window
//   apb       slave      psel / penable     window_length at byte address 0
//
// a sample pair that does not close a window, a restart or an ignored action is taken
// in the idle state and starts no product sequence
// a closing item runs six window products, then the denominator and squared numerator
// products, on one shared shift-add multiplier (one multiplier bit per cycle), then up to
// sixteen root search steps of two products each; a zero denominator skips everything
// after the sixth product
// input is held off (in_ch.ready low) while the window result is being computed and
// while it waits for the result register to free up
// the result register lets a new transfer in while the previous result waits on out_ch
// rst_n is synchronous; it clears the window sums and loads window_length with 2400
`default_nettype none

module windowed_stereo_correlation #(
  parameter int SAMPLE_BITS = wsc_pkg::SAMPLE_BITS,
  parameter int COUNT_BITS  = wsc_pkg::COUNT_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  wsc_in_if.sink                                   in_ch,
  wsc_out_if.source                                out_ch,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [wsc_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  wire logic [wsc_pkg::APB_DATA_BITS-1:0]   pwdata,
  output      logic [wsc_pkg::APB_DATA_BITS-1:0]   prdata,
  output      logic                                pready
);

  localparam int AB = wsc_pkg::APB_ADDR_BITS;

  // window length register
  logic [wsc_pkg::WINDOW_BITS-1:0] window_length_r;
  logic                            reg_hit;

  assign reg_hit = (paddr[AB-1:2] == wsc_pkg::REG_WINDOW_LENGTH);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= wsc_pkg::WINDOW_LENGTH_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      window_length_r <= pwdata[wsc_pkg::WINDOW_BITS-1:0];
    end
  end

  assign prdata = reg_hit ? wsc_pkg::APB_DATA_BITS'(window_length_r) : '0;

  // control and status between sequencer and datapath
  wsc_pkg::wsc_cmd_t cmd;
  wsc_pkg::wsc_sts_t sts;

  wsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wsc_dpath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_action     (in_ch.action),
    .in_left       (in_ch.left_sample),
    .in_right      (in_ch.right_sample),
    .window_length (window_length_r),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_corr      (out_ch.correlation),
    .out_samples   (out_ch.window_samples),
    .out_partial   (out_ch.partial_window)
  );

endmodule

`default_nettype wire
